// ===== hdl/octn_enc_pkg.sv =====
// shared types and constants for the octahedral normal encoder
`default_nettype none

package octn_enc_pkg;

    localparam int HALF_W = 16;

    typedef logic [HALF_W-1:0] t_half;

    typedef struct packed {
        logic valid;
        logic invalid;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== hdl/octn_enc_prep.sv =====
// front stages: magnitudes, sum, hemisphere fold, scaled numerators
`default_nettype none

module octn_enc_prep #(
    parameter int COMP_WIDTH = 16,
    parameter int CODE_WIDTH = 16,
    localparam int SW = COMP_WIDTH + 1,
    localparam int DW = COMP_WIDTH + 2,
    localparam int NW = DW + CODE_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [COMP_WIDTH-1:0]   i_norm_x,
    input  wire logic [COMP_WIDTH-1:0]   i_norm_y,
    input  wire logic [COMP_WIDTH-1:0]   i_norm_z,
    output octn_enc_pkg::t_ctrl          o_ctrl,
    output logic [DW-1:0]                o_div,
    output logic [DW-1:0]                o_rem_p,
    output logic [CODE_WIDTH-1:0]        o_lo_p,
    output logic [DW-1:0]                o_rem_q,
    output logic [CODE_WIDTH-1:0]        o_lo_q
);

    // stage 1: sign-extended components and magnitudes
    logic [SW-1:0] n_s1_x, n_s1_y, n_s1_z;
    logic [SW-1:0] n_s1_ax, n_s1_ay, n_s1_az;
    logic          r_s1_vld;
    logic [SW-1:0] r_s1_x, r_s1_y;
    logic [SW-1:0] r_s1_ax, r_s1_ay, r_s1_az;
    logic          r_s1_xneg, r_s1_yneg, r_s1_zneg;

    // stage 2: sum of magnitudes
    logic          r_s2_vld;
    logic [SW-1:0] r_s2_x, r_s2_y;
    logic [SW-1:0] r_s2_ax, r_s2_ay;
    logic [SW-1:0] r_s2_s;
    logic          r_s2_xneg, r_s2_yneg, r_s2_zneg;

    // stage 3: shifted coordinates t+s and divisor 2s
    logic [DW-1:0]       n_s3_s2, n_s3_ap, n_s3_aq;
    logic                r_s3_vld, r_s3_inv;
    logic [DW-1:0]       r_s3_ap, r_s3_aq, r_s3_div;

    // stage 4: numerators (t+s)*(2^k-1) split into start remainder and low bits
    logic [NW-1:0]       n_s4_np, n_s4_nq;
    logic                r_s4_vld, r_s4_inv;
    logic [DW-1:0]       r_s4_div;
    logic [NW-1:0]       r_s4_np, r_s4_nq;

    always_comb begin
        n_s1_x  = {i_norm_x[COMP_WIDTH-1], i_norm_x};
        n_s1_y  = {i_norm_y[COMP_WIDTH-1], i_norm_y};
        n_s1_z  = {i_norm_z[COMP_WIDTH-1], i_norm_z};
        n_s1_ax = i_norm_x[COMP_WIDTH-1] ? SW'(~n_s1_x + SW'(1)) : n_s1_x;
        n_s1_ay = i_norm_y[COMP_WIDTH-1] ? SW'(~n_s1_y + SW'(1)) : n_s1_y;
        n_s1_az = i_norm_z[COMP_WIDTH-1] ? SW'(~n_s1_z + SW'(1)) : n_s1_z;
    end

    always_comb begin
        n_s3_s2 = {r_s2_s, 1'b0};
        if (!r_s2_zneg) begin
            n_s3_ap = DW'({r_s2_x[SW-1], r_s2_x}) + DW'(r_s2_s);
            n_s3_aq = DW'({r_s2_y[SW-1], r_s2_y}) + DW'(r_s2_s);
        end else begin
            // folded: t+s is |y| for negative x, else 2s-|y| (same for q)
            n_s3_ap = r_s2_xneg ? DW'(r_s2_ay) : DW'(n_s3_s2 - DW'(r_s2_ay));
            n_s3_aq = r_s2_yneg ? DW'(r_s2_ax) : DW'(n_s3_s2 - DW'(r_s2_ax));
        end
    end

    always_comb begin
        n_s4_np = {r_s3_ap, CODE_WIDTH'(0)} - NW'(r_s3_ap);
        n_s4_nq = {r_s3_aq, CODE_WIDTH'(0)} - NW'(r_s3_aq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x    <= n_s1_x;
        r_s1_y    <= n_s1_y;
        r_s1_ax   <= n_s1_ax;
        r_s1_ay   <= n_s1_ay;
        r_s1_az   <= n_s1_az;
        r_s1_xneg <= i_norm_x[COMP_WIDTH-1];
        r_s1_yneg <= i_norm_y[COMP_WIDTH-1];
        r_s1_zneg <= i_norm_z[COMP_WIDTH-1];

        r_s2_x    <= r_s1_x;
        r_s2_y    <= r_s1_y;
        r_s2_ax   <= r_s1_ax;
        r_s2_ay   <= r_s1_ay;
        r_s2_s    <= SW'(r_s1_ax + r_s1_ay + r_s1_az);
        r_s2_xneg <= r_s1_xneg;
        r_s2_yneg <= r_s1_yneg;
        r_s2_zneg <= r_s1_zneg;

        r_s3_ap   <= n_s3_ap;
        r_s3_aq   <= n_s3_aq;
        r_s3_div  <= n_s3_s2;
        r_s3_inv  <= (r_s2_s == '0);

        r_s4_np   <= n_s4_np;
        r_s4_nq   <= n_s4_nq;
        r_s4_div  <= r_s3_div;
        r_s4_inv  <= r_s3_inv;
    end

    assign o_ctrl  = '{valid: r_s4_vld, invalid: r_s4_inv};
    assign o_div   = r_s4_div;
    assign o_rem_p = r_s4_np[NW-1:CODE_WIDTH];
    assign o_lo_p  = r_s4_np[CODE_WIDTH-1:0];
    assign o_rem_q = r_s4_nq[NW-1:CODE_WIDTH];
    assign o_lo_q  = r_s4_nq[CODE_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== hdl/octn_enc_cell.sv =====
// one restoring-division cell: one quotient bit for each of the two codes
`default_nettype none

module octn_enc_cell #(
    parameter int DW = 18,
    parameter int QW = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  octn_enc_pkg::t_ctrl       i_ctrl,
    input  wire logic [DW-1:0]        i_div,
    input  wire logic [DW-1:0]        i_rem_p,
    input  wire logic [QW-1:0]        i_lo_p,
    input  wire logic [QW-1:0]        i_quo_p,
    input  wire logic [DW-1:0]        i_rem_q,
    input  wire logic [QW-1:0]        i_lo_q,
    input  wire logic [QW-1:0]        i_quo_q,
    output octn_enc_pkg::t_ctrl       o_ctrl,
    output logic [DW-1:0]             o_div,
    output logic [DW-1:0]             o_rem_p,
    output logic [QW-1:0]             o_lo_p,
    output logic [QW-1:0]             o_quo_p,
    output logic [DW-1:0]             o_rem_q,
    output logic [QW-1:0]             o_lo_q,
    output logic [QW-1:0]             o_quo_q
);

    logic [DW:0]         trial_p, trial_q, div_x;
    logic                ge_p, ge_q;
    logic [DW-1:0]       n_rem_p, n_rem_q;
    logic                r_vld, r_inv;
    logic [DW-1:0]       r_div, r_rem_p, r_rem_q;
    logic [QW-1:0]       r_lo_p, r_lo_q, r_quo_p, r_quo_q;

    always_comb begin
        div_x   = {1'b0, i_div};
        trial_p = {i_rem_p, i_lo_p[QW-1]};
        trial_q = {i_rem_q, i_lo_q[QW-1]};
        ge_p    = (trial_p >= div_x);
        ge_q    = (trial_q >= div_x);
        n_rem_p = ge_p ? DW'(trial_p - div_x) : DW'(trial_p);
        n_rem_q = ge_q ? DW'(trial_q - div_x) : DW'(trial_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv   <= i_ctrl.invalid;
        r_div   <= i_div;
        r_rem_p <= n_rem_p;
        r_rem_q <= n_rem_q;
        r_lo_p  <= {i_lo_p[QW-2:0], 1'b0};
        r_lo_q  <= {i_lo_q[QW-2:0], 1'b0};
        r_quo_p <= {i_quo_p[QW-2:0], ge_p};
        r_quo_q <= {i_quo_q[QW-2:0], ge_q};
    end

    assign o_ctrl  = '{valid: r_vld, invalid: r_inv};
    assign o_div   = r_div;
    assign o_rem_p = r_rem_p;
    assign o_lo_p  = r_lo_p;
    assign o_quo_p = r_quo_p;
    assign o_rem_q = r_rem_q;
    assign o_lo_q  = r_lo_q;
    assign o_quo_q = r_quo_q;

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_inv) |-> (r_rem_p < r_div && r_rem_q < r_div))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ===== hdl/octahedral_normal_encoder_unit.sv =====
// top level of the octahedral normal encoder: front stages and division cell row
//
// channel   direction  handshake        payload
// command   in         start / busy     i_norm_x, i_norm_y, i_norm_z
// result    out        o_valid strobe   o_packed_code, o_invalid
//
// one vector is taken every cycle; busy stays low
// the pipeline has four front stages, then one cell per code bit
// each result is shown for one cycle under o_valid and cannot be held off
// reset clears only the valid chain; data registers carry no reset
`default_nettype none

module octahedral_normal_encoder_unit #(
    parameter int COMP_WIDTH = 16,
    parameter int CODE_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [COMP_WIDTH-1:0]   i_norm_x,
    input  wire logic [COMP_WIDTH-1:0]   i_norm_y,
    input  wire logic [COMP_WIDTH-1:0]   i_norm_z,
    output logic                         o_valid,
    output logic [31:0]                  o_packed_code,
    output logic                         o_invalid
);

    localparam int DW  = COMP_WIDTH + 2;
    localparam int LAT = 4 + CODE_WIDTH;
    localparam logic [CODE_WIDTH-1:0] HALF_CODE = {1'b0, {(CODE_WIDTH-1){1'b1}}};

    octn_enc_pkg::t_ctrl   ctrl_c  [CODE_WIDTH+1];
    logic [DW-1:0]         div_c   [CODE_WIDTH+1];
    logic [DW-1:0]         rem_p_c [CODE_WIDTH+1];
    logic [DW-1:0]         rem_q_c [CODE_WIDTH+1];
    logic [CODE_WIDTH-1:0] lo_p_c  [CODE_WIDTH+1];
    logic [CODE_WIDTH-1:0] lo_q_c  [CODE_WIDTH+1];
    logic [CODE_WIDTH-1:0] quo_p_c [CODE_WIDTH+1];
    logic [CODE_WIDTH-1:0] quo_q_c [CODE_WIDTH+1];

    assign busy = 1'b0;

    octn_enc_prep #(
        .COMP_WIDTH (COMP_WIDTH),
        .CODE_WIDTH (CODE_WIDTH)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_norm_x (i_norm_x),
        .i_norm_y (i_norm_y),
        .i_norm_z (i_norm_z),
        .o_ctrl   (ctrl_c[0]),
        .o_div    (div_c[0]),
        .o_rem_p  (rem_p_c[0]),
        .o_lo_p   (lo_p_c[0]),
        .o_rem_q  (rem_q_c[0]),
        .o_lo_q   (lo_q_c[0])
    );

    assign quo_p_c[0] = '0;
    assign quo_q_c[0] = '0;

    for (genvar g = 0; g < CODE_WIDTH; g++) begin : g_cell
        octn_enc_cell #(
            .DW (DW),
            .QW (CODE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl_c[g]),
            .i_div   (div_c[g]),
            .i_rem_p (rem_p_c[g]),
            .i_lo_p  (lo_p_c[g]),
            .i_quo_p (quo_p_c[g]),
            .i_rem_q (rem_q_c[g]),
            .i_lo_q  (lo_q_c[g]),
            .i_quo_q (quo_q_c[g]),
            .o_ctrl  (ctrl_c[g+1]),
            .o_div   (div_c[g+1]),
            .o_rem_p (rem_p_c[g+1]),
            .o_lo_p  (lo_p_c[g+1]),
            .o_quo_p (quo_p_c[g+1]),
            .o_rem_q (rem_q_c[g+1]),
            .o_lo_q  (lo_q_c[g+1]),
            .o_quo_q (quo_q_c[g+1])
        );
    end

    always_comb begin
        o_valid   = ctrl_c[CODE_WIDTH].valid;
        o_invalid = ctrl_c[CODE_WIDTH].invalid;
        if (ctrl_c[CODE_WIDTH].invalid) begin
            o_packed_code = {octn_enc_pkg::t_half'(HALF_CODE),
                             octn_enc_pkg::t_half'(HALF_CODE)};
        end else begin
            o_packed_code = {octn_enc_pkg::t_half'(quo_p_c[CODE_WIDTH]),
                             octn_enc_pkg::t_half'(quo_q_c[CODE_WIDTH])};
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("transfer accepted but no result after pipeline latency");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without accepted transfer");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |->
            $past(i_norm_x == '0 && i_norm_y == '0 && i_norm_z == '0, LAT))
        else $error("invalid flag for nonzero vector");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invalid) |->
            $past(i_norm_x != '0 || i_norm_y != '0 || i_norm_z != '0, LAT))
        else $error("zero vector not flagged invalid");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the octahedral normal encoder: directed and random vectors against a scoreboard
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COMP_W   = 16;
    localparam int CODE_W   = 16;
    localparam int LATENCY  = 4 + CODE_W;
    localparam int N_RANDOM = 510;

    typedef struct {
        octn_enc_pkg::t_half code_p;
        octn_enc_pkg::t_half code_q;
        logic                inv;
    } t_octa_code;

    class normal_code_board;
        t_octa_code codes_due[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function t_octa_code octa_code(logic signed [COMP_W-1:0] x,
                                       logic signed [COMP_W-1:0] y,
                                       logic signed [COMP_W-1:0] z);
            t_octa_code r;
            longint sx, sy, sz, ax, ay, az, s, p, q, cmax;
            sx   = x;
            sy   = y;
            sz   = z;
            ax   = (sx < 0) ? -sx : sx;
            ay   = (sy < 0) ? -sy : sy;
            az   = (sz < 0) ? -sz : sz;
            s    = ax + ay + az;
            cmax = (64'd1 << CODE_W) - 1;
            if (s == 0) begin
                r.code_p = octn_enc_pkg::t_half'(cmax >> 1);
                r.code_q = octn_enc_pkg::t_half'(cmax >> 1);
                r.inv    = 1'b1;
                return r;
            end
            if (sz >= 0) begin
                p = sx;
                q = sy;
            end else begin
                p = s - ay;
                q = s - ax;
                if (sx < 0) p = -p;
                if (sy < 0) q = -q;
            end
            r.code_p = octn_enc_pkg::t_half'(((p + s) * cmax) / (2 * s));
            r.code_q = octn_enc_pkg::t_half'(((q + s) * cmax) / (2 * s));
            r.inv    = 1'b0;
            return r;
        endfunction

        function void note_vector(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                                  logic [COMP_W-1:0] z);
            codes_due.insert(codes_due.size(), octa_code(x, y, z));
        endfunction

        function void check_code(logic [31:0] code, logic inv);
            t_octa_code e;
            if (codes_due.size() == 0) begin
                $display("%0t: unexpected result code %h invalid %b", $time, code, inv);
                errors++;
                return;
            end
            e = codes_due.pop_front();
            if (code[31:16] !== e.code_p) begin
                $display("%0t: x half expected %h actual %h", $time, e.code_p, code[31:16]);
                errors++;
            end
            if (code[15:0] !== e.code_q) begin
                $display("%0t: y half expected %h actual %h", $time, e.code_q, code[15:0]);
                errors++;
            end
            if (inv !== e.inv) begin
                $display("%0t: invalid expected %b actual %b", $time, e.inv, inv);
                errors++;
            end
        endfunction

        function int pending();
            return codes_due.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n  = 1'b0;
    logic              start    = 1'b0;
    logic              busy;
    logic [COMP_W-1:0] i_norm_x = '0;
    logic [COMP_W-1:0] i_norm_y = '0;
    logic [COMP_W-1:0] i_norm_z = '0;
    logic              o_valid;
    logic [31:0]       o_packed_code;
    logic              o_invalid;

    normal_code_board board = new();

    octahedral_normal_encoder_unit #(
        .COMP_WIDTH(COMP_W),
        .CODE_WIDTH(CODE_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_norm_x     (i_norm_x),
        .i_norm_y     (i_norm_y),
        .i_norm_z     (i_norm_z),
        .o_valid      (o_valid),
        .o_packed_code(o_packed_code),
        .o_invalid    (o_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            board.check_code(o_packed_code, o_invalid);
        end
    end

    task automatic send_vector(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                               logic [COMP_W-1:0] z, int idle_pct);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_norm_x <= x;
        i_norm_y <= y;
        i_norm_z <= z;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) break;
        end
        board.note_vector(x, y, z);
    endtask

    function automatic logic [COMP_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hffff;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7ffe;
            default: return 16'h7fff;
        endcase
    endfunction

    function automatic logic [COMP_W-1:0] pick_small();
        int v;
        v = int'($urandom_range(0, 16)) - 8;
        return COMP_W'(v);
    endfunction

    task automatic run_random(int n, int idle_pct);
        logic [COMP_W-1:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            x = COMP_W'($urandom);
            y = COMP_W'($urandom);
            z = COMP_W'($urandom);
            case ($urandom_range(0, 9))
                4: begin
                    x = pick_small();
                    y = pick_small();
                    z = pick_small();
                end
                5: begin
                    if ($urandom_range(1)) x = '0;
                    if ($urandom_range(1)) y = '0;
                    else z = '0;
                end
                6: begin
                    x = pick_extreme();
                    y = pick_extreme();
                    z = pick_extreme();
                end
                7: z[COMP_W-1] = 1'b1;
                8: z = '0;
                9: begin
                    x = $urandom_range(1) ? '0 : pick_small();
                    y = $urandom_range(1) ? '0 : pick_small();
                    z = $urandom_range(1) ? '0 : pick_small();
                end
                default: ;
            endcase
            send_vector(x, y, z, idle_pct);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_vector(16'h0000, 16'h0000, 16'h0000, 38);
        send_vector(16'h7fff, 16'h0000, 16'h0000, 38);
        send_vector(16'h8000, 16'h0000, 16'h0000, 38);
        send_vector(16'h0000, 16'h7fff, 16'h0000, 38);
        send_vector(16'h0000, 16'h8000, 16'h0000, 38);
        send_vector(16'h0000, 16'h0000, 16'h7fff, 38);
        send_vector(16'h0000, 16'h0000, 16'h8000, 38);
        send_vector(16'h8000, 16'h8000, 16'h8000, 38);
        send_vector(16'h7fff, 16'h7fff, 16'h7fff, 38);
        send_vector(16'h8000, 16'h8000, 16'h7fff, 38);
        send_vector(16'h7fff, 16'h8000, 16'h8000, 38);
        send_vector(16'h0000, 16'h0000, 16'hffff, 38);
        send_vector(16'h0001, 16'h0000, 16'hffff, 38);
        send_vector(16'h0000, 16'hffff, 16'hffff, 38);
        send_vector(16'hffff, 16'h0001, 16'hffff, 38);
        send_vector(16'hffff, 16'hffff, 16'h0000, 38);
        send_vector(16'h0001, 16'h0001, 16'h0001, 38);
        send_vector(16'h8000, 16'h7fff, 16'hffff, 38);
        send_vector(16'd12345, -16'sd23456, -16'sd3210, 38);
        send_vector(16'h0000, 16'h0005, 16'hfffb, 38);

        run_random(N_RANDOM, 38);
        run_random(N_RANDOM, 67);
        run_random(N_RANDOM, 0);
        start <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/octn_enc_pkg.sv
hdl/octn_enc_prep.sv
hdl/octn_enc_cell.sv
hdl/octahedral_normal_encoder_unit.sv
tb/sv/tb_top.sv
